@@ sv/cfdsp_pkg.sv @@
// Shared types and constants for the centralized FIFO task dispatcher.
// Used by cfdsp_ctrl, cfdsp_dp and the top level; depends on nothing.
package cfdsp_pkg;

  // Default sizes
  localparam int MAX_TASKS_DEF = 64;
  localparam int NUM_CPUS_DEF  = 8;

  // Stream payload widths
  localparam int IN_TDATA_W  = 56;
  localparam int IN_TUSER_W  = 4;
  localparam int OUT_TDATA_W = 48;
  localparam int OUT_TUSER_W = 2;
  localparam int GCPU_W      = 3;

  // Event codes
  localparam logic [3:0] OP_NEW       = 4'd0;
  localparam logic [3:0] OP_RUNNABLE  = 4'd1;
  localparam logic [3:0] OP_DEPARTED  = 4'd2;
  localparam logic [3:0] OP_DEAD      = 4'd3;
  localparam logic [3:0] OP_YIELD     = 4'd4;
  localparam logic [3:0] OP_BLOCKED   = 4'd5;
  localparam logic [3:0] OP_PREEMPTED = 4'd6;
  localparam logic [3:0] OP_SCHEDULE  = 4'd7;
  localparam logic [3:0] OP_COMMIT    = 4'd8;

  // Task states
  localparam logic [1:0] TS_FREE    = 2'd0;
  localparam logic [1:0] TS_BLOCKED = 2'd1;
  localparam logic [1:0] TS_QUEUED  = 2'd2;
  localparam logic [1:0] TS_RUNNING = 2'd3;

  // Result kinds
  localparam logic [1:0] KIND_ACK    = 2'd0;
  localparam logic [1:0] KIND_ASSIGN = 2'd1;
  localparam logic [1:0] KIND_NONE   = 2'd2;

  // Result status codes
  localparam logic [1:0] RS_OK      = 2'd0;
  localparam logic [1:0] RS_ILLEGAL = 2'd1;
  localparam logic [1:0] RS_FULL    = 2'd2;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_DISP, S_CMT, S_TCHK, S_OWN,
    S_ER_RD, S_ER_CMP, S_SH_RD, S_SH_WR,
    S_SC_CHK, S_SC_RQ, S_SC_T, S_SC_S, S_SC_END, S_RES
  } state_t;

  typedef enum logic [1:0] {TTA_TID, TTA_TK, TTA_CLR} tt_addr_t;
  typedef enum logic [1:0] {TTC_NONE, TTC_CC, TTC_KEEP} tt_cpu_t;
  typedef enum logic [1:0] {RQA_BACK, RQA_FRONT, RQA_SHIFT} rq_addr_t;
  typedef enum logic [1:0] {RQD_TID, RQD_TK, RQD_RAM} rq_data_t;
  typedef enum logic [1:0] {OUT_RES, OUT_HELD, OUT_NONE} out_sel_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic       capture;
    logic       clr_step;
    logic       tt_we;
    tt_addr_t   tt_addr;
    logic [1:0] tt_stat;
    tt_cpu_t    tt_cpu;
    logic       seq_we;
    logic       rq_we;
    rq_addr_t   rq_addr;
    rq_data_t   rq_data;
    logic       rq_rd_next;
    logic       q_pop;
    logic       q_dec;
    logic       busy_clr;
    logic       busy_set;
    logic       pend_clr;
    logic       cpu_we;
    logic       k_inc;
    logic       c_inc;
    logic       a_save;
    logic       seq_rd_rq;
    logic       hold_load;
    logic       hold_clr;
    logic       st_set;
    logic [1:0] st_val;
    logic       out_load;
    out_sel_t   out_sel;
    logic       out_last;
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic [3:0] op;
    logic       tid_ok;
    logic [1:0] tstat;
    logic       own;
    logic       cc_ok;
    logic       ok;
    logic       run;
    logic       full;
    logic       q_empty;
    logic       scan_end;
    logic       match;
    logic       shift_more;
    logic       c_end;
    logic       c_elig;
    logic       hold_v;
    logic       out_free;
    logic       clr_done;
  } sts_t;

endpackage

@@ sv/centralized_fifo_task_dispatcher_core.sv @@
// Top level of the centralized FIFO task dispatcher.
// Depends on cfdsp_pkg, cfdsp_ctrl, cfdsp_dp (which holds the cfdsp_ram instances).
//
//  Channel | Ports                              | Contents
//  --------+------------------------------------+-------------------------------
//  cfg     | cfg_we, cfg_wdata[2:0]             | global_cpu
//  in      | in_tvalid/tready, tdata, tuser     | one scheduling event
//  out     | out_tvalid/tready, tdata, tuser,   | one result; tlast on final one
//          | tlast                              |
//
// Plain events pass dispatch, state checks and result, plus output handshake; a
// dequeue from mid-queue reads and compares each scanned entry and reads and writes
// each shifted one. Schedule checks CPUs in turn, each assignment via the request,
// table and send states. After reset a clearing pass frees the task table; no event
// is accepted meanwhile. A stalled output holds the sequencer at its next result.
module centralized_fifo_task_dispatcher_core #(
  parameter int MAX_TASKS = cfdsp_pkg::MAX_TASKS_DEF,
  parameter int NUM_CPUS  = cfdsp_pkg::NUM_CPUS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [cfdsp_pkg::GCPU_W-1:0]      cfg_wdata,   // global_cpu
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // task_id[5:0], event_seqnum[37:6], starts_runnable[38], usable_cpus[46:39],
  // commit_cpu[49:47], commit_ok[50], zero pad
  input  logic [cfdsp_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  logic [cfdsp_pkg::IN_TUSER_W-1:0]  in_tuser,    // operation[3:0]
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // assigned_cpu[2:0], assigned_task[8:3], target_seqnum[40:9], status[42:41], zero pad
  output logic [cfdsp_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic [cfdsp_pkg::OUT_TUSER_W-1:0] out_tuser,   // kind[1:0]
  output logic                              out_tlast    // last
);

  cfdsp_pkg::cmd_t cmd;
  cfdsp_pkg::sts_t sts;

  cfdsp_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .sts(sts), .cmd(cmd)
  );

  cfdsp_dp #(.MAX_TASKS(MAX_TASKS), .NUM_CPUS(NUM_CPUS)) u_dp (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser), .out_tlast(out_tlast),
    .cmd(cmd), .sts(sts)
  );

endmodule

@@ sv/cfdsp_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module cfdsp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ sv/cfdsp_ctrl.sv @@
// Controller state machine of the task dispatcher.
// Depends on cfdsp_pkg; drives cfdsp_dp through cmd_t and reads sts_t.
module cfdsp_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  input  cfdsp_pkg::sts_t sts,
  output cfdsp_pkg::cmd_t cmd
);

  cfdsp_pkg::state_t state_r, state_nxt;
  logic is_dep_blk, is_yield_pre;

  assign is_dep_blk   = (sts.op == cfdsp_pkg::OP_DEPARTED) || (sts.op == cfdsp_pkg::OP_BLOCKED);
  assign is_yield_pre = (sts.op == cfdsp_pkg::OP_YIELD) || (sts.op == cfdsp_pkg::OP_PREEMPTED);
  assign in_tready    = (state_r == cfdsp_pkg::S_IDLE);

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= cfdsp_pkg::S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      cfdsp_pkg::S_CLEAR: if (sts.clr_done) state_nxt = cfdsp_pkg::S_IDLE;
      cfdsp_pkg::S_IDLE:  if (in_tvalid) state_nxt = cfdsp_pkg::S_DISP;
      cfdsp_pkg::S_DISP: begin
        if (sts.op == cfdsp_pkg::OP_SCHEDULE) begin
          state_nxt = cfdsp_pkg::S_SC_CHK;
        end else if (sts.op == cfdsp_pkg::OP_COMMIT) begin
          state_nxt = sts.cc_ok ? cfdsp_pkg::S_CMT : cfdsp_pkg::S_RES;
        end else if (sts.op > cfdsp_pkg::OP_COMMIT || !sts.tid_ok) begin
          state_nxt = cfdsp_pkg::S_RES;
        end else begin
          state_nxt = cfdsp_pkg::S_TCHK;
        end
      end
      cfdsp_pkg::S_CMT: state_nxt = cfdsp_pkg::S_RES;
      cfdsp_pkg::S_TCHK: begin
        state_nxt = cfdsp_pkg::S_RES;
        if ((is_dep_blk || is_yield_pre) && sts.tstat == cfdsp_pkg::TS_RUNNING) begin
          state_nxt = cfdsp_pkg::S_OWN;
        end else if (is_dep_blk && sts.tstat == cfdsp_pkg::TS_QUEUED) begin
          state_nxt = cfdsp_pkg::S_ER_RD;
        end
      end
      cfdsp_pkg::S_OWN:    state_nxt = cfdsp_pkg::S_RES;
      cfdsp_pkg::S_ER_RD:  state_nxt = sts.scan_end ? cfdsp_pkg::S_RES : cfdsp_pkg::S_ER_CMP;
      cfdsp_pkg::S_ER_CMP: state_nxt = sts.match ? cfdsp_pkg::S_SH_RD : cfdsp_pkg::S_ER_RD;
      cfdsp_pkg::S_SH_RD:  state_nxt = sts.shift_more ? cfdsp_pkg::S_SH_WR : cfdsp_pkg::S_RES;
      cfdsp_pkg::S_SH_WR:  state_nxt = cfdsp_pkg::S_SH_RD;
      cfdsp_pkg::S_SC_CHK: begin
        if (sts.c_end || sts.q_empty) begin
          state_nxt = cfdsp_pkg::S_SC_END;
        end else if (sts.c_elig) begin
          state_nxt = cfdsp_pkg::S_SC_RQ;
        end
      end
      cfdsp_pkg::S_SC_RQ: state_nxt = cfdsp_pkg::S_SC_T;
      cfdsp_pkg::S_SC_T:  state_nxt = cfdsp_pkg::S_SC_S;
      cfdsp_pkg::S_SC_S:  if (!sts.hold_v || sts.out_free) state_nxt = cfdsp_pkg::S_SC_CHK;
      cfdsp_pkg::S_SC_END: if (sts.out_free) state_nxt = cfdsp_pkg::S_IDLE;
      cfdsp_pkg::S_RES:    if (sts.out_free) state_nxt = cfdsp_pkg::S_IDLE;
      default: state_nxt = cfdsp_pkg::S_IDLE;
    endcase
  end

  // Command outputs
  always_comb begin
    cmd         = '0;
    cmd.tt_addr = cfdsp_pkg::TTA_TID;
    cmd.tt_cpu  = cfdsp_pkg::TTC_NONE;
    cmd.rq_addr = cfdsp_pkg::RQA_BACK;
    cmd.rq_data = cfdsp_pkg::RQD_TID;
    cmd.out_sel = cfdsp_pkg::OUT_RES;
    unique case (state_r)
      cfdsp_pkg::S_CLEAR: begin
        cmd.clr_step = 1'b1;
        cmd.tt_we    = 1'b1;
        cmd.tt_addr  = cfdsp_pkg::TTA_CLR;
        cmd.tt_stat  = cfdsp_pkg::TS_FREE;
      end
      cfdsp_pkg::S_IDLE: cmd.capture = in_tvalid;
      cfdsp_pkg::S_DISP: begin
        if (sts.op == cfdsp_pkg::OP_COMMIT) begin
          if (!sts.cc_ok) begin
            cmd.st_set = 1'b1;
            cmd.st_val = cfdsp_pkg::RS_ILLEGAL;
          end
        end else if (sts.op != cfdsp_pkg::OP_SCHEDULE &&
                     (sts.op > cfdsp_pkg::OP_COMMIT || !sts.tid_ok)) begin
          cmd.st_set = 1'b1;
          cmd.st_val = cfdsp_pkg::RS_ILLEGAL;
        end
      end
      cfdsp_pkg::S_CMT: begin
        if (sts.ok) begin
          cmd.tt_we    = 1'b1;
          cmd.tt_addr  = cfdsp_pkg::TTA_TK;
          cmd.tt_stat  = cfdsp_pkg::TS_RUNNING;
          cmd.tt_cpu   = cfdsp_pkg::TTC_CC;
          cmd.pend_clr = 1'b1;
        end else if (sts.full) begin
          cmd.st_set = 1'b1;
          cmd.st_val = cfdsp_pkg::RS_FULL;
        end else begin
          cmd.rq_we    = 1'b1;
          cmd.rq_addr  = cfdsp_pkg::RQA_FRONT;
          cmd.rq_data  = cfdsp_pkg::RQD_TK;
          cmd.busy_clr = 1'b1;
          cmd.pend_clr = 1'b1;
        end
      end
      cfdsp_pkg::S_TCHK: begin
        case (sts.op) inside
          cfdsp_pkg::OP_NEW: begin
            if (sts.tstat != cfdsp_pkg::TS_FREE) begin
              cmd.st_set = 1'b1;
              cmd.st_val = cfdsp_pkg::RS_ILLEGAL;
            end else if (sts.run && sts.full) begin
              cmd.st_set = 1'b1;
              cmd.st_val = cfdsp_pkg::RS_FULL;
            end else begin
              cmd.rq_we   = sts.run;
              cmd.tt_we   = 1'b1;
              cmd.tt_stat = sts.run ? cfdsp_pkg::TS_QUEUED : cfdsp_pkg::TS_BLOCKED;
              cmd.seq_we  = 1'b1;
            end
          end
          cfdsp_pkg::OP_RUNNABLE: begin
            if (sts.tstat != cfdsp_pkg::TS_BLOCKED) begin
              cmd.st_set = 1'b1;
              cmd.st_val = cfdsp_pkg::RS_ILLEGAL;
            end else if (sts.full) begin
              cmd.st_set = 1'b1;
              cmd.st_val = cfdsp_pkg::RS_FULL;
            end else begin
              cmd.rq_we   = 1'b1;
              cmd.tt_we   = 1'b1;
              cmd.tt_stat = cfdsp_pkg::TS_QUEUED;
              cmd.tt_cpu  = cfdsp_pkg::TTC_KEEP;
            end
          end
          cfdsp_pkg::OP_DEAD: begin
            if (sts.tstat != cfdsp_pkg::TS_BLOCKED) begin
              cmd.st_set = 1'b1;
              cmd.st_val = cfdsp_pkg::RS_ILLEGAL;
            end else begin
              cmd.tt_we   = 1'b1;
              cmd.tt_stat = cfdsp_pkg::TS_FREE;
            end
          end
          cfdsp_pkg::OP_DEPARTED, cfdsp_pkg::OP_BLOCKED: begin
            if (sts.tstat == cfdsp_pkg::TS_RUNNING || sts.tstat == cfdsp_pkg::TS_QUEUED) begin
              cmd.st_set = 1'b0;
            end else if (sts.op == cfdsp_pkg::OP_DEPARTED &&
                         sts.tstat == cfdsp_pkg::TS_BLOCKED) begin
              cmd.tt_we   = 1'b1;
              cmd.tt_stat = cfdsp_pkg::TS_FREE;
            end else begin
              cmd.st_set = 1'b1;
              cmd.st_val = cfdsp_pkg::RS_ILLEGAL;
            end
          end
          cfdsp_pkg::OP_YIELD, cfdsp_pkg::OP_PREEMPTED: begin
            if (sts.tstat != cfdsp_pkg::TS_RUNNING) begin
              cmd.st_set = 1'b1;
              cmd.st_val = cfdsp_pkg::RS_ILLEGAL;
            end
          end
          default: cmd.st_set = 1'b0;
        endcase
      end
      cfdsp_pkg::S_OWN: begin
        if (!sts.own) begin
          cmd.st_set = 1'b1;
          cmd.st_val = cfdsp_pkg::RS_ILLEGAL;
        end else if (is_dep_blk) begin
          cmd.busy_clr = 1'b1;
          cmd.tt_we    = 1'b1;
          cmd.tt_stat  = (sts.op == cfdsp_pkg::OP_DEPARTED) ? cfdsp_pkg::TS_FREE
                                                            : cfdsp_pkg::TS_BLOCKED;
        end else if (sts.full) begin
          cmd.st_set = 1'b1;
          cmd.st_val = cfdsp_pkg::RS_FULL;
        end else begin
          cmd.rq_we    = 1'b1;
          cmd.rq_addr  = (sts.op == cfdsp_pkg::OP_YIELD) ? cfdsp_pkg::RQA_BACK
                                                         : cfdsp_pkg::RQA_FRONT;
          cmd.busy_clr = 1'b1;
          cmd.tt_we    = 1'b1;
          cmd.tt_stat  = cfdsp_pkg::TS_QUEUED;
        end
      end
      cfdsp_pkg::S_ER_RD: begin
        if (sts.scan_end) begin
          cmd.st_set = 1'b1;
          cmd.st_val = cfdsp_pkg::RS_ILLEGAL;
        end
      end
      cfdsp_pkg::S_ER_CMP: cmd.k_inc = !sts.match;
      cfdsp_pkg::S_SH_RD: begin
        if (sts.shift_more) begin
          cmd.rq_rd_next = 1'b1;
        end else begin
          cmd.q_dec   = 1'b1;
          cmd.tt_we   = 1'b1;
          cmd.tt_stat = (sts.op == cfdsp_pkg::OP_DEPARTED) ? cfdsp_pkg::TS_FREE
                                                           : cfdsp_pkg::TS_BLOCKED;
        end
      end
      cfdsp_pkg::S_SH_WR: begin
        cmd.rq_we   = 1'b1;
        cmd.rq_addr = cfdsp_pkg::RQA_SHIFT;
        cmd.rq_data = cfdsp_pkg::RQD_RAM;
        cmd.k_inc   = 1'b1;
      end
      cfdsp_pkg::S_SC_CHK: cmd.c_inc = !(sts.c_end || sts.q_empty) && !sts.c_elig;
      cfdsp_pkg::S_SC_RQ:  cmd.st_set = 1'b0;
      cfdsp_pkg::S_SC_T: begin
        cmd.cpu_we    = 1'b1;
        cmd.busy_set  = 1'b1;
        cmd.q_pop     = 1'b1;
        cmd.a_save    = 1'b1;
        cmd.seq_rd_rq = 1'b1;
      end
      cfdsp_pkg::S_SC_S: begin
        if (!sts.hold_v || sts.out_free) begin
          cmd.out_load  = sts.hold_v;
          cmd.out_sel   = cfdsp_pkg::OUT_HELD;
          cmd.hold_load = 1'b1;
          cmd.c_inc     = 1'b1;
        end
      end
      cfdsp_pkg::S_SC_END: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_sel  = sts.hold_v ? cfdsp_pkg::OUT_HELD : cfdsp_pkg::OUT_NONE;
          cmd.out_last = 1'b1;
          cmd.hold_clr = 1'b1;
        end
      end
      cfdsp_pkg::S_RES: begin
        cmd.out_load = sts.out_free;
        cmd.out_last = 1'b1;
      end
      default: cmd.st_set = 1'b0;
    endcase
  end

  // An accepted event always moves on to dispatch
  a_accept_disp: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (state_r == cfdsp_pkg::S_DISP))
    else $error("accepted event did not reach dispatch");

endmodule

@@ sv/cfdsp_dp.sv @@
// Datapath of the task dispatcher: run queue, task tables, CPU state, output register.
// Depends on cfdsp_pkg and cfdsp_ram; controlled by cfdsp_ctrl through cmd_t.
module cfdsp_dp #(
  parameter int MAX_TASKS = cfdsp_pkg::MAX_TASKS_DEF,
  parameter int NUM_CPUS  = cfdsp_pkg::NUM_CPUS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [cfdsp_pkg::GCPU_W-1:0]      cfg_wdata,
  input  logic [cfdsp_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  logic [cfdsp_pkg::IN_TUSER_W-1:0]  in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [cfdsp_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic [cfdsp_pkg::OUT_TUSER_W-1:0] out_tuser,
  output logic                              out_tlast,
  input  cfdsp_pkg::cmd_t                   cmd,
  output cfdsp_pkg::sts_t                   sts
);

  localparam int TW  = $clog2(MAX_TASKS);
  localparam int CTW = $clog2(MAX_TASKS + 1);
  localparam int CW  = $clog2(NUM_CPUS);
  localparam int CNW = $clog2(NUM_CPUS + 1);
  localparam int TTW = 2 + CNW;

  // Queue position to RAM address, wrapping at MAX_TASKS
  function automatic logic [TW-1:0] qidx(input logic [TW-1:0] base, input logic [CTW:0] off);
    logic [CTW+1:0] sum;
    sum = (CTW+2)'(base) + (CTW+2)'(off);
    if (sum >= (CTW+2)'(MAX_TASKS)) sum = sum - (CTW+2)'(MAX_TASKS);
    return TW'(sum);
  endfunction

  // Captured event
  logic [3:0]  op_r;
  logic [5:0]  tid_r;
  logic [31:0] seq_r;
  logic        run_r;
  logic [7:0]  usable_r;
  logic [2:0]  cc_r;
  logic        ok_r;

  logic [2:0]          gcpu_r;
  logic [TW-1:0]       head_r;
  logic [CTW-1:0]      count_r;
  logic [NUM_CPUS-1:0] busy_r, pend_r;
  logic [CTW-1:0]      k_r;
  logic [CNW-1:0]      c_r;
  logic [TW-1:0]       clr_r;
  logic [TW-1:0]       a_task_r;
  logic [1:0]          st_r;
  logic                hold_v_r;
  logic [2:0]          hold_cpu_r;
  logic [5:0]          hold_task_r;
  logic [31:0]         hold_seq_r;
  logic                out_valid_r;
  logic [1:0]          out_kind_r, out_status_r;
  logic [2:0]          out_cpu_r;
  logic [5:0]          out_task_r;
  logic [31:0]         out_seq_r;
  logic                out_last_r;

  logic [TW-1:0]       tid_idx, rq_rdata, cpu_rdata, rq_waddr, rq_wdata, front_addr;
  logic [TW-1:0]       tt_waddr, seq_raddr;
  logic [CW-1:0]       cc_idx, tc_idx, c_idx, busy_idx, cpu_raddr;
  logic [TTW-1:0]      tt_rdata, tt_wdata;
  logic [CNW-1:0]      tc, tt_wcpu;
  logic [31:0]         seq_rdata;
  logic [NUM_CPUS-1:0] umask;
  logic                out_free;

  assign tid_idx  = TW'(tid_r);
  assign cc_idx   = CW'(cc_r);
  assign tc       = tt_rdata[CNW-1:0];
  assign tc_idx   = CW'(tc);
  assign c_idx    = CW'(c_r);
  assign busy_idx = (op_r == cfdsp_pkg::OP_COMMIT) ? cc_idx : tc_idx;
  assign out_free = !out_valid_r || out_tready;

  // CPUs numbered 8 and up have no usable bit
  always_comb begin
    for (int i = 0; i < NUM_CPUS; i++) begin
      umask[i] = (i < 8) ? usable_r[3'(i)] : 1'b0;
    end
  end

  // Run queue write address and data
  assign front_addr = (head_r == '0) ? TW'(MAX_TASKS - 1) : head_r - TW'(1);
  always_comb begin
    case (cmd.rq_addr)
      cfdsp_pkg::RQA_FRONT: rq_waddr = front_addr;
      cfdsp_pkg::RQA_SHIFT: rq_waddr = qidx(head_r, (CTW+1)'(k_r));
      default:              rq_waddr = qidx(head_r, (CTW+1)'(count_r));
    endcase
    case (cmd.rq_data)
      cfdsp_pkg::RQD_TK:  rq_wdata = cpu_rdata;
      cfdsp_pkg::RQD_RAM: rq_wdata = rq_rdata;
      default:            rq_wdata = tid_idx;
    endcase
  end

  // Task table write address and data
  always_comb begin
    case (cmd.tt_addr)
      cfdsp_pkg::TTA_TK:  tt_waddr = cpu_rdata;
      cfdsp_pkg::TTA_CLR: tt_waddr = clr_r;
      default:            tt_waddr = tid_idx;
    endcase
    case (cmd.tt_cpu)
      cfdsp_pkg::TTC_CC:   tt_wcpu = CNW'(cc_r);
      cfdsp_pkg::TTC_KEEP: tt_wcpu = tc;
      default:             tt_wcpu = CNW'(NUM_CPUS);
    endcase
  end
  assign tt_wdata  = {cmd.tt_stat, tt_wcpu};
  assign seq_raddr = cmd.seq_rd_rq ? rq_rdata : a_task_r;
  assign cpu_raddr = (op_r == cfdsp_pkg::OP_COMMIT) ? cc_idx : tc_idx;

  // Memories
  cfdsp_ram #(.WIDTH(TW), .DEPTH(MAX_TASKS)) u_rq (
    .clk(clk), .we(cmd.rq_we), .waddr(rq_waddr), .wdata(rq_wdata),
    .raddr(qidx(head_r, (CTW+1)'(k_r) + (CTW+1)'(cmd.rq_rd_next))), .rdata(rq_rdata)
  );
  cfdsp_ram #(.WIDTH(TTW), .DEPTH(MAX_TASKS)) u_tt (
    .clk(clk), .we(cmd.tt_we), .waddr(tt_waddr), .wdata(tt_wdata),
    .raddr(tid_idx), .rdata(tt_rdata)
  );
  cfdsp_ram #(.WIDTH(32), .DEPTH(MAX_TASKS)) u_seq (
    .clk(clk), .we(cmd.seq_we), .waddr(tid_idx), .wdata(seq_r),
    .raddr(seq_raddr), .rdata(seq_rdata)
  );
  cfdsp_ram #(.WIDTH(TW), .DEPTH(NUM_CPUS)) u_cpu (
    .clk(clk), .we(cmd.cpu_we), .waddr(c_idx), .wdata(rq_rdata),
    .raddr(cpu_raddr), .rdata(cpu_rdata)
  );

  // Event capture and payload registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r     <= in_tuser;
      tid_r    <= in_tdata[5:0];
      seq_r    <= in_tdata[37:6];
      run_r    <= in_tdata[38];
      usable_r <= in_tdata[46:39];
      cc_r     <= in_tdata[49:47];
      ok_r     <= in_tdata[50];
    end
    if (cmd.a_save) a_task_r <= rq_rdata;
    if (cmd.hold_load) begin
      hold_cpu_r  <= 3'(c_r);
      hold_task_r <= 6'(a_task_r);
      hold_seq_r  <= seq_rdata;
    end
    if (cmd.out_load) begin
      out_last_r <= cmd.out_last;
      case (cmd.out_sel)
        cfdsp_pkg::OUT_HELD: begin
          out_kind_r   <= cfdsp_pkg::KIND_ASSIGN;
          out_cpu_r    <= hold_cpu_r;
          out_task_r   <= hold_task_r;
          out_seq_r    <= hold_seq_r;
          out_status_r <= cfdsp_pkg::RS_OK;
        end
        cfdsp_pkg::OUT_NONE: begin
          out_kind_r   <= cfdsp_pkg::KIND_NONE;
          out_cpu_r    <= '0;
          out_task_r   <= '0;
          out_seq_r    <= '0;
          out_status_r <= cfdsp_pkg::RS_OK;
        end
        default: begin
          out_kind_r   <= cfdsp_pkg::KIND_ACK;
          out_cpu_r    <= '0;
          out_task_r   <= '0;
          out_seq_r    <= '0;
          out_status_r <= st_r;
        end
      endcase
    end
  end

  // Control state: queue pointers, CPU flags, scan counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gcpu_r      <= '0;
      head_r      <= '0;
      count_r     <= '0;
      busy_r      <= '0;
      pend_r      <= '0;
      k_r         <= '0;
      c_r         <= '0;
      clr_r       <= '0;
      st_r        <= cfdsp_pkg::RS_OK;
      hold_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) gcpu_r <= cfg_wdata;
      if (cmd.clr_step) clr_r <= clr_r + TW'(1);
      if (cmd.capture) begin
        k_r  <= '0;
        c_r  <= '0;
        st_r <= cfdsp_pkg::RS_OK;
      end
      if (cmd.k_inc) k_r <= k_r + CTW'(1);
      if (cmd.c_inc) c_r <= c_r + CNW'(1);
      if (cmd.st_set) st_r <= cmd.st_val;
      // queue pointers
      if (cmd.rq_we && cmd.rq_addr == cfdsp_pkg::RQA_BACK) count_r <= count_r + CTW'(1);
      if (cmd.rq_we && cmd.rq_addr == cfdsp_pkg::RQA_FRONT) begin
        head_r  <= front_addr;
        count_r <= count_r + CTW'(1);
      end
      if (cmd.q_pop) begin
        head_r  <= (head_r == TW'(MAX_TASKS - 1)) ? '0 : head_r + TW'(1);
        count_r <= count_r - CTW'(1);
      end
      if (cmd.q_dec) count_r <= count_r - CTW'(1);
      // CPU flags
      if (cmd.busy_clr) busy_r[busy_idx] <= 1'b0;
      if (cmd.pend_clr) pend_r[cc_idx] <= 1'b0;
      if (cmd.busy_set) begin
        busy_r[c_idx] <= 1'b1;
        pend_r[c_idx] <= 1'b1;
      end
      // held assignment and output valid
      if (cmd.hold_load) hold_v_r <= 1'b1;
      if (cmd.hold_clr) hold_v_r <= 1'b0;
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Status to controller
  always_comb begin
    sts.op         = op_r;
    sts.tid_ok     = 32'(tid_r) < MAX_TASKS;
    sts.tstat      = tt_rdata[TTW-1:CNW];
    sts.own        = (32'(tc) < NUM_CPUS) && busy_r[tc_idx] && (cpu_rdata == tid_idx);
    sts.cc_ok      = (32'(cc_r) < NUM_CPUS) && pend_r[cc_idx] && busy_r[cc_idx];
    sts.ok         = ok_r;
    sts.run        = run_r;
    sts.full       = 32'(count_r) >= MAX_TASKS;
    sts.q_empty    = (count_r == '0);
    sts.scan_end   = (k_r == count_r);
    sts.match      = (rq_rdata == tid_idx);
    sts.shift_more = ((CTW+1)'(k_r) + (CTW+1)'(1)) < (CTW+1)'(count_r);
    sts.c_end      = 32'(c_r) >= NUM_CPUS;
    sts.c_elig     = (32'(c_r) != 32'(gcpu_r)) && umask[c_idx] && !busy_r[c_idx];
    sts.hold_v     = hold_v_r;
    sts.out_free   = out_free;
    sts.clr_done   = (clr_r == TW'(MAX_TASKS - 1));
  end

  // Stream outputs
  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {5'b0, out_status_r, out_seq_r, out_task_r, out_cpu_r};

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    32'(count_r) <= MAX_TASKS)
    else $error("run queue count out of range");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> out_free)
    else $error("output register overwritten before transfer");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.q_pop |-> (count_r != '0))
    else $error("pop from empty run queue");

endmodule

@@ verif/centralized_fifo_task_dispatcher_core_test.sv @@
// Self-checking testbench for centralized_fifo_task_dispatcher_core: a directed table,
// then random scheduling traffic checked against a built-in scheduler predictor.
// Depends on cfdsp_pkg and the dispatcher RTL only.
module centralized_fifo_task_dispatcher_core_test;
  import cfdsp_pkg::*;

  localparam int NT = MAX_TASKS_DEF;
  localparam int NC = NUM_CPUS_DEF;

  typedef struct packed {
    logic [1:0]  kind;
    logic [2:0]  cpu;
    logic [5:0]  task_id;
    logic [31:0] seq;
    logic [1:0]  status;
    logic        last;
  } result_t;

  typedef struct {
    logic [3:0]  op;
    logic [5:0]  tid;
    logic [31:0] seq;
    logic        run;
    logic [7:0]  usable;
    logic [2:0]  cc;
    logic        ok;
    logic        chk;
    logic [1:0]  st;
  } event_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [GCPU_W-1:0] cfg_wdata = '0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  // task_id, event_seqnum, starts_runnable, usable_cpus, commit_cpu, commit_ok, pad
  logic [IN_TDATA_W-1:0] in_tdata = '0;
  logic [IN_TUSER_W-1:0] in_tuser = '0;  // operation
  logic out_tvalid;
  logic out_tready = 1'b0;
  // assigned_cpu, assigned_task, target_seqnum, status, pad
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [OUT_TUSER_W-1:0] out_tuser;     // kind
  logic out_tlast;

  centralized_fifo_task_dispatcher_core DUT (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser), .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser), .out_tlast(out_tlast)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Scheduler state mirror
  logic [2:0]  gcpu;
  logic [5:0]  runq [NT];
  int          qhead, qcount;
  logic [1:0]  tstate [NT];
  int          tcpu [NT];
  logic [31:0] tseq [NT];
  logic [5:0]  cur [NC];
  logic [NC-1:0] busy, pend;

  result_t pending_results [$];
  int errors = 0;
  bit quiet = 1'b0;

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    errors++;
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
  endtask

  function automatic void post(input logic [1:0] k, input logic [2:0] c, input logic [5:0] t,
                               input logic [31:0] s, input logic [1:0] st, input logic l);
    result_t r;
    r.kind = k; r.cpu = c; r.task_id = t; r.seq = s; r.status = st; r.last = l;
    pending_results.push_back(r);
  endfunction

  function automatic bit push_back_task(input logic [5:0] t);
    if (qcount >= NT) return 0;
    runq[(qhead + qcount) % NT] = t;
    qcount++;
    return 1;
  endfunction

  function automatic bit push_front_task(input logic [5:0] t);
    if (qcount >= NT) return 0;
    qhead = (qhead + NT - 1) % NT;
    runq[qhead] = t;
    qcount++;
    return 1;
  endfunction

  function automatic bit erase_task(input logic [5:0] t);
    int i;
    i = 0;
    while (i < qcount && runq[(qhead + i) % NT] != t) i++;
    if (i >= qcount) return 0;
    for (int j = i; j + 1 < qcount; j++) runq[(qhead + j) % NT] = runq[(qhead + j + 1) % NT];
    qcount--;
    return 1;
  endfunction

  function automatic bit on_own_cpu(input logic [5:0] t);
    int c;
    c = tcpu[t];
    return tstate[t] == TS_RUNNING && c < NC && busy[c] && cur[c] == t;
  endfunction

  // Apply one event to the mirror, queue its results, return first status
  function automatic logic [1:0] dispatch_event(input event_t e);
    logic [1:0] st;
    logic [5:0] t, tk;
    int n;
    st = RS_OK; t = e.tid; n = 0;
    if (e.op == OP_SCHEDULE) begin
      for (int c = 0; c < NC && qcount > 0; c++) begin
        if (c == gcpu || !e.usable[c] || busy[c]) continue;
        tk = runq[qhead];
        qhead = (qhead + 1) % NT;
        qcount--;
        cur[c] = tk; busy[c] = 1'b1; pend[c] = 1'b1;
        post(KIND_ASSIGN, c[2:0], tk, tseq[tk], RS_OK, 1'b0);
        n++;
      end
      if (n == 0) post(KIND_NONE, '0, '0, '0, RS_OK, 1'b1);
      else pending_results[$].last = 1'b1;
      return RS_OK;
    end
    if (e.op == OP_COMMIT) begin
      if (!pend[e.cc] || !busy[e.cc]) st = RS_ILLEGAL;
      else begin
        tk = cur[e.cc];
        if (e.ok) begin
          tstate[tk] = TS_RUNNING; tcpu[tk] = e.cc; pend[e.cc] = 1'b0;
        end else if (push_front_task(tk)) begin
          busy[e.cc] = 1'b0; pend[e.cc] = 1'b0;
        end else st = RS_FULL;
      end
    end else begin
      case (e.op)
        OP_NEW: begin
          if (tstate[t] != TS_FREE) st = RS_ILLEGAL;
          else if (e.run && !push_back_task(t)) st = RS_FULL;
          else begin
            tstate[t] = e.run ? TS_QUEUED : TS_BLOCKED;
            tseq[t] = e.seq; tcpu[t] = NC;
          end
        end
        OP_RUNNABLE: begin
          if (tstate[t] != TS_BLOCKED) st = RS_ILLEGAL;
          else if (!push_back_task(t)) st = RS_FULL;
          else tstate[t] = TS_QUEUED;
        end
        OP_DEPARTED, OP_BLOCKED: begin
          if (tstate[t] == TS_RUNNING) begin
            if (!on_own_cpu(t)) st = RS_ILLEGAL;
            else busy[tcpu[t]] = 1'b0;
          end else if (tstate[t] == TS_QUEUED) begin
            if (!erase_task(t)) st = RS_ILLEGAL;
          end else if (!(e.op == OP_DEPARTED && tstate[t] == TS_BLOCKED)) st = RS_ILLEGAL;
          if (st == RS_OK) begin
            tstate[t] = (e.op == OP_DEPARTED) ? TS_FREE : TS_BLOCKED;
            tcpu[t] = NC;
          end
        end
        OP_DEAD: begin
          if (tstate[t] != TS_BLOCKED) st = RS_ILLEGAL;
          else begin
            tstate[t] = TS_FREE; tcpu[t] = NC;
          end
        end
        OP_YIELD, OP_PREEMPTED: begin
          if (!on_own_cpu(t)) st = RS_ILLEGAL;
          else if (!(e.op == OP_YIELD ? push_back_task(t) : push_front_task(t))) st = RS_FULL;
          else begin
            busy[tcpu[t]] = 1'b0; tstate[t] = TS_QUEUED; tcpu[t] = NC;
          end
        end
        default: st = RS_ILLEGAL;
      endcase
    end
    post(KIND_ACK, '0, '0, '0, st, 1'b1);
    return st;
  endfunction

  // Input side: optional gap, then one transfer
  task automatic send_event(input event_t e);
    logic [1:0] st;
    if (!quiet && $urandom_range(99) < 23) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= e.op;
    in_tdata <= {5'd0, e.ok, e.cc, e.usable, e.run, e.seq, e.tid};
    do @(posedge clk); while (!in_tready);
    st = dispatch_event(e);
    if (e.chk && st != e.st) report("directed status", st, e.st);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  task automatic write_gcpu(input logic [2:0] v);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    gcpu = v;
  endtask

  // Random event biased toward legal transitions of the chosen task
  function automatic event_t random_event();
    event_t e;
    int r, c;
    logic [5:0] t;
    e.tid = 6'($urandom); e.seq = $urandom; e.run = 1'($urandom); e.usable = 8'($urandom);
    e.cc = 3'($urandom); e.ok = ($urandom_range(99) < 75); e.chk = 1'b0; e.st = RS_OK;
    r = $urandom_range(99);
    if (r < 13) begin
      e.op = OP_SCHEDULE;
      if ($urandom_range(1)) e.usable = 8'hFF;
    end else if (r < 32) begin
      e.op = OP_COMMIT;
      if (pend != 0 && $urandom_range(9) != 0) begin
        c = $urandom_range(NC - 1);
        while (!pend[c]) c = (c + 1) % NC;
        e.cc = 3'(c);
      end
    end else if (r < 37) begin
      e.op = 4'($urandom_range(15));
    end else begin
      t = $urandom_range(1) ? 6'($urandom_range(11)) : 6'($urandom_range(63));
      e.tid = t;
      case (tstate[t])
        TS_FREE: begin
          e.op = OP_NEW;
          e.run = ($urandom_range(9) < 7);
        end
        TS_BLOCKED: begin
          r = $urandom_range(5);
          e.op = (r < 4) ? OP_RUNNABLE : (r == 4 ? OP_DEPARTED : OP_DEAD);
        end
        TS_QUEUED: e.op = $urandom_range(3) == 0 ? OP_DEPARTED : OP_BLOCKED;
        default: begin
          r = $urandom_range(3);
          e.op = r == 0 ? OP_YIELD : r == 1 ? OP_PREEMPTED : r == 2 ? OP_BLOCKED : OP_DEPARTED;
        end
      endcase
    end
    return e;
  endfunction

  // Output side: check each transfer, then choose next ready
  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) report("unexpected result", out_tuser, 0);
      else begin
        want = pending_results.pop_front();
        if (out_tuser != want.kind) report("kind", out_tuser, want.kind);
        if (out_tdata[2:0] != want.cpu) report("assigned_cpu", out_tdata[2:0], want.cpu);
        if (out_tdata[8:3] != want.task_id)
          report("assigned_task", out_tdata[8:3], want.task_id);
        if (out_tdata[40:9] != want.seq) report("target_seqnum", out_tdata[40:9], want.seq);
        if (out_tdata[42:41] != want.status)
          report("status", out_tdata[42:41], want.status);
        if (out_tlast != want.last) report("last", out_tlast, want.last);
      end
    end
    out_tready <= quiet || ($urandom_range(99) >= 23);
  end

  initial begin
    #4_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  initial begin
    event_t table_rows [$];
    qhead = 0; qcount = 0; gcpu = '0; busy = '0; pend = '0;
    for (int i = 0; i < NT; i++) begin
      tstate[i] = TS_FREE; tcpu[i] = NC; tseq[i] = '0; runq[i] = '0;
    end
    for (int i = 0; i < NC; i++) cur[i] = '0;

    //                 op            tid  seq           run usable cc ok chk st
    table_rows.push_back('{OP_COMMIT,    0, 32'd0,        0, 8'h00, 0, 1, 1, RS_ILLEGAL});
    table_rows.push_back('{4'd15,       63, 32'd0,        0, 8'h00, 0, 0, 1, RS_ILLEGAL});
    table_rows.push_back('{OP_DEAD,      0, 32'd0,        0, 8'h00, 0, 0, 1, RS_ILLEGAL});
    table_rows.push_back('{OP_SCHEDULE,  0, 32'd0,        0, 8'hFF, 0, 0, 1, RS_OK});
    table_rows.push_back('{OP_NEW,       0, 32'hFFFFFFFF, 1, 8'h00, 0, 0, 1, RS_OK});
    table_rows.push_back('{OP_NEW,      63, 32'd0,        0, 8'h00, 0, 0, 1, RS_OK});
    table_rows.push_back('{OP_NEW,       0, 32'd7,        1, 8'h00, 0, 0, 1, RS_ILLEGAL});
    table_rows.push_back('{OP_RUNNABLE, 63, 32'd0,        0, 8'h00, 0, 0, 1, RS_OK});
    table_rows.push_back('{OP_NEW,       5, 32'h12345678, 1, 8'h00, 0, 0, 1, RS_OK});
    table_rows.push_back('{OP_SCHEDULE,  0, 32'd0,        0, 8'h81, 0, 0, 0, RS_OK});
    table_rows.push_back('{OP_BLOCKED,   0, 32'd0,        0, 8'h00, 0, 0, 1, RS_ILLEGAL});
    table_rows.push_back('{OP_COMMIT,    0, 32'd0,        0, 8'h00, 0, 1, 1, RS_OK});
    table_rows.push_back('{OP_YIELD,     0, 32'd0,        0, 8'h00, 0, 0, 1, RS_OK});
    table_rows.push_back('{OP_SCHEDULE,  0, 32'd0,        0, 8'hFF, 0, 0, 0, RS_OK});
    table_rows.push_back('{OP_COMMIT,    0, 32'd0,        0, 8'h00, 1, 0, 1, RS_OK});
    table_rows.push_back('{OP_COMMIT,    0, 32'd0,        0, 8'h00, 0, 1, 1, RS_OK});
    table_rows.push_back('{OP_COMMIT,    0, 32'd0,        0, 8'h00, 2, 1, 1, RS_OK});
    table_rows.push_back('{OP_PREEMPTED, 63, 32'd0,       0, 8'h00, 0, 0, 1, RS_OK});
    table_rows.push_back('{OP_BLOCKED,   0, 32'd0,        0, 8'h00, 0, 0, 1, RS_OK});
    table_rows.push_back('{OP_DEPARTED, 63, 32'd0,        0, 8'h00, 0, 0, 1, RS_OK});
    table_rows.push_back('{OP_DEAD,      0, 32'd0,        0, 8'h00, 0, 0, 1, RS_OK});
    table_rows.push_back('{OP_DEPARTED,  5, 32'd0,        0, 8'h00, 0, 0, 1, RS_OK});
    table_rows.push_back('{4'd9,         1, 32'd0,        0, 8'h00, 0, 0, 1, RS_ILLEGAL});

    // Reset, then agent CPU at the top extreme
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    write_gcpu(3'd7);
    foreach (table_rows[i]) send_event(table_rows[i]);
    drain();

    // Random phases, each under its own agent CPU
    write_gcpu(3'd0);
    for (int i = 0; i < 230; i++) begin
      if (i == 70 || i == 150 || i == 200) begin
        drain();
        write_gcpu(i == 70 ? 3'd3 : i == 150 ? 3'($urandom_range(7)) : 3'd5);
      end
      quiet = (i >= 100 && i < 140);
      // Hold the sender until the block has answered everything
      if (i == 120) begin
        in_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
      end
      send_event(random_event());
    end
    quiet = 1'b0;
    drain();

    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end
endmodule

@@ sim.f @@
sv/cfdsp_pkg.sv
sv/cfdsp_ram.sv
sv/cfdsp_ctrl.sv
sv/cfdsp_dp.sv
sv/centralized_fifo_task_dispatcher_core.sv
verif/centralized_fifo_task_dispatcher_core_test.sv
